@@ sv/mic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types, constants and register indexes for the iron calibration block.
// ----------------------------------------------------------------------------
package mic_pkg;

  localparam int COUNT_BITS = 13;
  // compare width for counter against discard + sample target
  localparam int CMP_BITS   = ((COUNT_BITS > 13) ? COUNT_BITS : 13) + 1;
  localparam int LSB_NUM    = 49120;
  localparam int DEN_14     = 8190;
  localparam int DEN_16     = 32760;
  localparam int SOFT_ONE   = 16384;
  localparam int SOFT_MAX   = 65535;

  localparam logic [2:0] REG_FS   = 3'd0;
  localparam logic [2:0] REG_ADJX = 3'd1;
  localparam logic [2:0] REG_ADJY = 3'd2;
  localparam logic [2:0] REG_ADJZ = 3'd3;
  localparam logic [2:0] REG_DISC = 3'd4;
  localparam logic [2:0] REG_SAMP = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OVF   = 3'd1;
  localparam logic [2:0] ST_CAL   = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;
  localparam logic [2:0] ST_DEGEN = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_SOFT, S_CALDIV, S_OUT
  } state_t;

  // Serial divider request: magnitude numerator / denominator, rounded.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

@@ sv/mic_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_div
// Radix-2 restoring divider, one quotient bit per cycle, round half up on
// magnitudes (caller handles sign).
// ----------------------------------------------------------------------------
module mic_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mic_pkg::div_req_t req,
  output mic_pkg::div_rsp_t rsp
);
  import mic_pkg::*;

  logic [63:0] q_r, q_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [47:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [48:0] trial;
  logic [49:0] sub;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[47:0], q_r[63]};
    sub      = {1'b0, trial} - {2'b00, den_r};
    if (req.start) begin
      // add den/2 up front for rounding
      q_nxt    = req.num + {17'd0, req.den[47:1]};
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!sub[49]) begin
        rem_nxt = sub[48:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
endmodule

@@ sv/mic_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_mul
// Shift-add multiplier, one multiplier bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module mic_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] a,
  input  logic [15:0] b,
  output logic        done,
  output logic [63:0] p
);
  import mic_pkg::*;

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] a_r, a_nxt;
  logic [15:0] b_r, b_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = {16'd0, a};
      b_nxt    = b;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt   = {a_r[62:0], 1'b0};
      b_nxt   = {1'b0, b_r[15:1]};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

@@ sv/magnetometer_iron_calibration.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration
// Hard/soft iron correction of 3-axis magnetometer samples with min/max
// calibration.
// ----------------------------------------------------------------------------
// One request at a time. A measurement result becomes valid once, per axis, a
// serial 16-bit multiply and a 64-step serial divide for the scaling, then the
// same for the soft scale, have run, followed by the output state. The request
// that ends a calibration runs a multiply and divide per axis for the bias and
// a multiply and divide per axis for the soft scale (none for an axis of zero
// range), followed by the output state. Other requests give their result the
// cycle after they are taken. The result register is held until taken; the
// next request is taken once it is.
module magnetometer_iron_calibration (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic signed [15:0] in_raw_x,
  input  logic signed [15:0] in_raw_y,
  input  logic signed [15:0] in_raw_z,
  input  logic        in_overflow,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic signed [31:0] out_mag_x,
  output logic signed [31:0] out_mag_y,
  output logic signed [31:0] out_mag_z,
  output logic signed [23:0] out_hard_out_x,
  output logic signed [23:0] out_hard_out_y,
  output logic signed [23:0] out_hard_out_z,
  output logic [15:0] out_soft_out_x,
  output logic [15:0] out_soft_out_y,
  output logic [15:0] out_soft_out_z
);
  import mic_pkg::*;

  logic        fs_r;
  logic [7:0]  adj_r [3];
  logic [9:0]  disc_r;
  logic [11:0] samp_r;

  state_t state_r, state_nxt;
  logic        cal_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic signed [15:0] mx_r [3];
  logic signed [15:0] mn_r [3];
  logic signed [23:0] hb_r [3];
  logic [15:0] ss_r [3];
  logic signed [15:0] raw_r [3];
  logic signed [31:0] mag_r [3];
  logic [16:0] rng_r [3];
  logic [18:0] tot_r;
  logic [1:0]  ax_r;
  logic        ph_r;       // 0: multiply phase, 1: divide phase
  logic        neg_r;
  logic        go_r;
  logic        degen_r;
  logic [2:0]  st_r;
  logic        ov_r;

  logic        mul_start, mul_done;
  logic [47:0] mul_a;
  logic [15:0] mul_b;
  logic [63:0] mul_p;
  div_req_t    dreq;
  div_rsp_t    drsp;

  mic_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .p(mul_p));
  mic_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic in_fire, out_fire;
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_fire  = ov_r && out_ready;

  // helpers for current axis
  logic signed [16:0] v2;          // scale numerator (2*raw or max+min)
  logic [16:0] v2_mag;
  logic [8:0]  adjo;
  logic [47:0] lsbden2;
  logic signed [32:0] diff;        // scaled - bias
  logic [32:0] diff_mag;
  logic signed [24:0] scaled;
  logic signed [64:0] qs;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [12:0]          eff;
  logic [CMP_BITS-1:0]  target;
  logic                 cal_end;

  always_comb begin
    if (st_r == ST_CAL) v2 = 17'(mx_r[ax_r]) + 17'(mn_r[ax_r]);
    else                v2 = {raw_r[ax_r], 1'b0};
    v2_mag  = v2[16] ? 17'(-v2) : 17'(v2);
    adjo    = {1'b0, adj_r[ax_r]} + 9'd128;
    lsbden2 = fs_r ? 48'(2 * 256 * DEN_16) : 48'(2 * 256 * DEN_14);
    scaled  = neg_r ? -25'(drsp.quo[23:0]) : 25'(drsp.quo[23:0]);
    diff    = 33'(scaled) - 33'(hb_r[ax_r]);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    qs      = neg_r ? -65'(drsp.quo) : 65'(drsp.quo);
    cnt_inc = cnt_r + 1'b1;
    eff     = (samp_r == 12'd0) ? 13'd1 : {1'b0, samp_r};
    target  = CMP_BITS'(disc_r) + CMP_BITS'(eff);
    cal_end = CMP_BITS'(cnt_inc) >= target;
  end

  // multiply inputs
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SCALE) begin
      mul_a = 48'(v2_mag) * 48'(LSB_NUM * 16);
      mul_b = 16'(adjo);
    end else if (state_r == S_SOFT) begin
      mul_a = 48'(diff_mag);
      mul_b = ss_r[ax_r];
    end else begin
      mul_a = 48'(tot_r);
      mul_b = 16'(SOFT_ONE);
    end
  end

  always_comb begin
    dreq.start = ph_r == 1'b0 && mul_done;
    dreq.num   = mul_p;
    dreq.den   = lsbden2;
    if (state_r == S_SOFT)   dreq.den = 48'(SOFT_ONE);
    if (state_r == S_CALDIV) dreq.den = 48'(rng_r[ax_r]) * 48'd3;
  end

  // no multiply for an axis of zero range
  assign mul_start = go_r && !(state_r == S_CALDIV && rng_r[ax_r] == 17'd0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire && !in_action && !in_overflow) begin
        if (!cal_r) state_nxt = S_SCALE;
        else if (cal_end) state_nxt = S_SCALE;
      end
      S_SCALE:  if (drsp.done) begin
        if (st_r == ST_CAL) begin
          if (ax_r == 2'd2) state_nxt = S_CALDIV;
        end else state_nxt = S_SOFT;
      end
      S_SOFT:   if (drsp.done) state_nxt = (ax_r == 2'd2) ? S_OUT : S_SCALE;
      S_CALDIV: if (drsp.done || (go_r && rng_r[ax_r] == 17'd0)) begin
        if (ax_r == 2'd2) state_nxt = S_OUT;
      end
      S_OUT:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  logic [15:0] sq;
  always_comb begin
    sq = (drsp.quo > 64'(SOFT_MAX)) ? 16'(SOFT_MAX) : drsp.quo[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      go_r    <= 1'b0;
      ph_r    <= 1'b0;
      cal_r   <= 1'b0;
      cnt_r   <= '0;
      fs_r    <= 1'b0;
      disc_r  <= 10'd100;
      samp_r  <= 12'd110;
      for (int i = 0; i < 3; i++) begin
        adj_r[i] <= 8'd128;
        mx_r[i]  <= -16'sd32767;
        mn_r[i]  <= 16'sd32767;
        hb_r[i]  <= '0;
        ss_r[i]  <= 16'(SOFT_ONE);
      end
    end else begin
      state_r <= state_nxt;
      go_r    <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_FS:   fs_r     <= cfg_data[0];
          REG_ADJX: adj_r[0] <= cfg_data[7:0];
          REG_ADJY: adj_r[1] <= cfg_data[7:0];
          REG_ADJZ: adj_r[2] <= cfg_data[7:0];
          REG_DISC: disc_r   <= cfg_data[9:0];
          REG_SAMP: samp_r   <= cfg_data;
          default: ;
        endcase
      end
      if (out_fire) ov_r <= 1'b0;
      if (mul_done) ph_r <= 1'b1;
      if (in_fire) begin
        raw_r[0] <= in_raw_x;
        raw_r[1] <= in_raw_y;
        raw_r[2] <= in_raw_z;
        ax_r     <= 2'd0;
        ph_r     <= 1'b0;
        degen_r  <= 1'b0;
        for (int i = 0; i < 3; i++) mag_r[i] <= '0;
        if (in_action) begin
          cal_r <= 1'b1;
          cnt_r <= '0;
          for (int i = 0; i < 3; i++) begin
            mx_r[i] <= -16'sd32767;
            mn_r[i] <= 16'sd32767;
          end
          st_r <= ST_CAL;
          ov_r <= 1'b1;
        end else if (in_overflow) begin
          st_r <= ST_OVF;
          ov_r <= 1'b1;
        end else if (cal_r) begin
          st_r <= ST_CAL;
          if (CMP_BITS'(cnt_r) >= CMP_BITS'(disc_r)) begin
            if (in_raw_x > mx_r[0]) mx_r[0] <= in_raw_x;
            if (in_raw_y > mx_r[1]) mx_r[1] <= in_raw_y;
            if (in_raw_z > mx_r[2]) mx_r[2] <= in_raw_z;
            if (in_raw_x < mn_r[0]) mn_r[0] <= in_raw_x;
            if (in_raw_y < mn_r[1]) mn_r[1] <= in_raw_y;
            if (in_raw_z < mn_r[2]) mn_r[2] <= in_raw_z;
          end
          cnt_r <= cnt_inc;
          if (cal_end) begin
            cal_r <= 1'b0;
            go_r  <= 1'b1;
          end else ov_r <= 1'b1;
        end else begin
          st_r <= ST_OK;
          go_r <= 1'b1;
        end
      end
      if (state_r == S_SCALE && go_r) neg_r <= v2[16];
      if (state_r == S_SOFT && go_r)  neg_r <= diff[32];
      if (state_r == S_SCALE && drsp.done) begin
        ph_r <= 1'b0;
        go_r <= 1'b1;
        if (st_r == ST_CAL) begin
          hb_r[ax_r] <= scaled[23:0];
          if (mx_r[ax_r] > mn_r[ax_r])
            rng_r[ax_r] <= 17'(17'(mx_r[ax_r]) - 17'(mn_r[ax_r]));
          else rng_r[ax_r] <= '0;
          if (ax_r == 2'd2) ax_r <= 2'd0;
          else ax_r <= ax_r + 2'd1;
        end
      end
      if (state_r == S_SOFT && drsp.done) begin
        mag_r[ax_r] <= qs[31:0];
        ph_r <= 1'b0;
        if (ax_r != 2'd2) begin
          ax_r <= ax_r + 2'd1;
          go_r <= 1'b1;
        end
      end
      if (state_r == S_SCALE && drsp.done && st_r == ST_CAL && ax_r == 2'd2)
        tot_r <= 19'(rng_r[0]) + 19'(rng_r[1]) +
                 19'(mx_r[2] > mn_r[2] ? 17'(17'(mx_r[2]) - 17'(mn_r[2])) : 17'd0);
      if (state_r == S_CALDIV) begin
        if (go_r && rng_r[ax_r] == 17'd0) begin
          ss_r[ax_r] <= 16'(SOFT_MAX);
          degen_r    <= 1'b1;
          go_r       <= 1'b0;
          ph_r       <= 1'b0;
          if (ax_r != 2'd2) begin
            ax_r <= ax_r + 2'd1;
            go_r <= 1'b1;
          end
        end else if (drsp.done) begin
          ss_r[ax_r] <= sq;
          ph_r <= 1'b0;
          if (ax_r != 2'd2) begin
            ax_r <= ax_r + 2'd1;
            go_r <= 1'b1;
          end
        end
      end
      if (state_r == S_OUT) begin
        ov_r <= 1'b1;
        if (st_r == ST_CAL) st_r <= degen_r ? ST_DEGEN : ST_DONE;
      end
    end
  end

  assign out_status     = st_r;
  assign out_mag_x      = mag_r[0];
  assign out_mag_y      = mag_r[1];
  assign out_mag_z      = mag_r[2];
  assign out_hard_out_x = hb_r[0];
  assign out_hard_out_y = hb_r[1];
  assign out_hard_out_z = hb_r[2];
  assign out_soft_out_x = ss_r[0];
  assign out_soft_out_y = ss_r[1];
  assign out_soft_out_z = ss_r[2];
endmodule

@@ sv/mic_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_checker
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
module mic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic signed [31:0] out_mag_x
);
  import mic_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after request taken");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_DEGEN)
    else $error("bad status");

  a_mag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_mag_x == 32'sd0)
    else $error("field nonzero outside ok");

endmodule

bind magnetometer_iron_calibration mic_checker u_mic_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_mag_x(out_mag_x)
);
